@@ src/fct_pkg.sv @@
// Shared types and constants of the flow-tracking packet classifier.
// Used by every module of the block but fct_ram, by the checker and the testbench.
// No dependencies.
package fct_pkg;

  // Header codes taken from the extracted fields.
  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [3:0]  IP_VER4 = 4'd4;
  localparam logic [3:0]  IP_VER6 = 4'd6;

  // Fixed header sizes in bytes.
  localparam logic [7:0] ETH_HDR_BYTES = 8'd14;
  localparam logic [5:0] IPV6_HDR_BYTES = 6'd40;
  localparam logic [5:0] UDP_HDR_BYTES = 6'd8;

  // Widths of result fields that do not follow the table size.
  localparam int FLOW_IDX_W = 6;
  localparam int FLOW_CNT_W = 7;

  // Result status codes.
  typedef enum logic [3:0] {
    ST_NON_IP    = 4'd0,
    ST_NOT_L4    = 4'd1,
    ST_FILTERED  = 4'd2,
    ST_TCP_KNOWN = 4'd3,
    ST_TCP_NEW   = 4'd4,
    ST_UDP_KNOWN = 4'd5,
    ST_UDP_NEW   = 4'd6,
    ST_TCP_FULL  = 4'd7,
    ST_UDP_FULL  = 4'd8
  } fct_status_t;

  // Lookup engine states.
  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_DONE
  } fct_state_t;

  // One packet's extracted header fields.
  typedef struct packed {
    logic [15:0] frame_type;
    logic [3:0]  ip_version;
    logic [3:0]  ip_header_words;
    logic [7:0]  next_protocol;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [3:0]  tcp_data_offset;
    logic [15:0] captured_length;
  } fct_in_t;

  // One flow table entry: the flow key. Tag bit 0 is UDP, bit 1 is IPv6.
  typedef struct packed {
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [31:0] ports;
    logic [1:0]  tag;
  } fct_entry_t;

  localparam int ENTRY_W = $bits(fct_entry_t);

  // Decoded packet handed from the parser to the lookup engine.
  typedef struct packed {
    logic        lookup;
    fct_status_t status;
    logic        udp;
    logic [5:0]  thl;
    logic [15:0] pay;
    fct_entry_t  key;
  } fct_job_t;

  // Finished packet handed from the engine to the counters and output stage.
  typedef struct packed {
    logic                  fire;
    fct_status_t           status;
    logic [5:0]            thl;
    logic [15:0]           pay;
    logic [FLOW_IDX_W-1:0] flow_index;
  } fct_result_t;

  // Counter values after a packet.
  typedef struct packed {
    logic [31:0]           total_packets;
    logic [31:0]           tcp_packet_total;
    logic [31:0]           udp_packet_total;
    logic [31:0]           tcp_byte_total;
    logic [31:0]           udp_byte_total;
    logic [FLOW_CNT_W-1:0] tcp_flow_total;
    logic [FLOW_CNT_W-1:0] udp_flow_total;
  } fct_counts_t;

endpackage

@@ src/fct_if.sv @@
// Valid/ready channel interfaces of the classifier: packet in, result out,
// and the filter register write. Depends on nothing but plain logic types.
interface fct_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_type;
  logic [3:0]  ip_version;
  logic [3:0]  ip_header_words;
  logic [7:0]  next_protocol;
  logic [63:0] src_addr_hi;
  logic [63:0] src_addr_lo;
  logic [63:0] dst_addr_hi;
  logic [63:0] dst_addr_lo;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [3:0]  tcp_data_offset;
  logic [15:0] captured_length;

  modport source (
    output valid, frame_type, ip_version, ip_header_words, next_protocol,
           src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo, src_port,
           dst_port, tcp_data_offset, captured_length,
    input  ready
  );
  modport sink (
    input  valid, frame_type, ip_version, ip_header_words, next_protocol,
           src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo, src_port,
           dst_port, tcp_data_offset, captured_length,
    output ready
  );
endinterface

interface fct_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [5:0]  transport_header_len;
  logic [15:0] payload_len;
  logic [5:0]  flow_index;
  logic [31:0] total_packets;
  logic [31:0] tcp_packet_total;
  logic [31:0] udp_packet_total;
  logic [31:0] tcp_byte_total;
  logic [31:0] udp_byte_total;
  logic [6:0]  tcp_flow_total;
  logic [6:0]  udp_flow_total;

  modport source (
    output valid, status, transport_header_len, payload_len, flow_index,
           total_packets, tcp_packet_total, udp_packet_total, tcp_byte_total,
           udp_byte_total, tcp_flow_total, udp_flow_total,
    input  ready
  );
  modport sink (
    input  valid, status, transport_header_len, payload_len, flow_index,
           total_packets, tcp_packet_total, udp_packet_total, tcp_byte_total,
           udp_byte_total, tcp_flow_total, udp_flow_total,
    output ready
  );
endinterface

interface fct_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] port_filter;

  modport source (output valid, port_filter, input ready);
  modport sink (input valid, port_filter, output ready);
endinterface

@@ src/fct_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module fct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/fct_parse.sv @@
// Header decode: classifies one packet, derives header and payload lengths
// and builds the flow key. Depends on fct_pkg.
module fct_parse (
  input  fct_pkg::fct_in_t  pkt,
  input  logic [15:0]       port_filter,
  output fct_pkg::fct_job_t job
);

  logic       is_ip;
  logic       l4_ok;
  logic       udp;
  logic       v6;
  logic       filtered;
  logic [5:0] thl_raw;
  logic [5:0] iphl;
  logic [7:0] hdrs;

  // Classification of the packet.
  always_comb begin
    is_ip = (pkt.frame_type == fct_pkg::ETH_IPV4) || (pkt.frame_type == fct_pkg::ETH_IPV6);
    l4_ok = ((pkt.ip_version == fct_pkg::IP_VER4) || (pkt.ip_version == fct_pkg::IP_VER6)) &&
            ((pkt.next_protocol == fct_pkg::PROTO_TCP) ||
             (pkt.next_protocol == fct_pkg::PROTO_UDP));
    udp = (pkt.next_protocol == fct_pkg::PROTO_UDP);
    v6 = (pkt.ip_version == fct_pkg::IP_VER6);
    filtered = (port_filter != 16'd0) && (pkt.src_port != port_filter);
  end

  // Header lengths; the sum stays below 256.
  always_comb begin
    thl_raw = udp ? fct_pkg::UDP_HDR_BYTES : {pkt.tcp_data_offset, 2'b00};
    iphl = v6 ? fct_pkg::IPV6_HDR_BYTES : {pkt.ip_header_words, 2'b00};
    hdrs = fct_pkg::ETH_HDR_BYTES + {2'b00, iphl} + {2'b00, thl_raw};
  end

  // Job for the engine. Dropped packets carry zero payload length.
  always_comb begin
    job.lookup = is_ip && l4_ok && !filtered;
    priority if (!is_ip) begin
      job.status = fct_pkg::ST_NON_IP;
    end else if (!l4_ok) begin
      job.status = fct_pkg::ST_NOT_L4;
    end else begin
      job.status = fct_pkg::ST_FILTERED;
    end
    job.udp = udp;
    job.thl = (is_ip && l4_ok) ? thl_raw : 6'd0;
    if (job.lookup && (pkt.captured_length > {8'd0, hdrs})) begin
      job.pay = pkt.captured_length - {8'd0, hdrs};
    end else begin
      job.pay = 16'd0;
    end
    // IPv4 addresses keep only their low 32 bits.
    job.key.src_hi = v6 ? pkt.src_addr_hi : 64'd0;
    job.key.dst_hi = v6 ? pkt.dst_addr_hi : 64'd0;
    job.key.src_lo = v6 ? pkt.src_addr_lo : {32'd0, pkt.src_addr_lo[31:0]};
    job.key.dst_lo = v6 ? pkt.dst_addr_lo : {32'd0, pkt.dst_addr_lo[31:0]};
    job.key.ports = {pkt.src_port, pkt.dst_port};
    job.key.tag = {v6, udp};
  end

endmodule

@@ src/fct_stats.sv @@
// Per-protocol packet, byte and flow counters, advanced once per finished
// packet. Depends on fct_pkg.
module fct_stats (
  input  logic                   clk,
  input  logic                   rst,
  input  fct_pkg::fct_result_t   res,
  output fct_pkg::fct_counts_t   counts_next
);

  fct_pkg::fct_counts_t counts;
  logic is_tcp;
  logic is_udp;
  logic tcp_new;
  logic udp_new;

  // Which counters this packet touches.
  always_comb begin
    is_tcp = (res.status == fct_pkg::ST_TCP_KNOWN) || (res.status == fct_pkg::ST_TCP_NEW) ||
             (res.status == fct_pkg::ST_TCP_FULL);
    is_udp = (res.status == fct_pkg::ST_UDP_KNOWN) || (res.status == fct_pkg::ST_UDP_NEW) ||
             (res.status == fct_pkg::ST_UDP_FULL);
    tcp_new = (res.status == fct_pkg::ST_TCP_NEW);
    udp_new = (res.status == fct_pkg::ST_UDP_NEW);
  end

  // Counter values after this packet; all wrap.
  always_comb begin
    counts_next.total_packets = counts.total_packets + 32'd1;
    counts_next.tcp_packet_total = counts.tcp_packet_total + {31'd0, is_tcp};
    counts_next.udp_packet_total = counts.udp_packet_total + {31'd0, is_udp};
    counts_next.tcp_byte_total = counts.tcp_byte_total + (is_tcp ? {16'd0, res.pay} : 32'd0);
    counts_next.udp_byte_total = counts.udp_byte_total + (is_udp ? {16'd0, res.pay} : 32'd0);
    counts_next.tcp_flow_total = counts.tcp_flow_total +
                                 fct_pkg::FLOW_CNT_W'(tcp_new);
    counts_next.udp_flow_total = counts.udp_flow_total +
                                 fct_pkg::FLOW_CNT_W'(udp_new);
  end

  // Counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      counts <= '0;
    end else if (res.fire) begin
      counts <= counts_next;
    end
  end

endmodule

@@ src/fct_engine.sv @@
// Flow lookup engine: scans the flow memory one entry per cycle, appends
// new flows and hands out one finished packet. Depends on fct_pkg, fct_ram.
module fct_engine #(
  parameter int FLOW_ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  fct_pkg::fct_job_t    job_in,
  input  logic                 out_free,
  output logic                 idle,
  output fct_pkg::fct_result_t res
);

  localparam int IW = $clog2(FLOW_ENTRIES);
  localparam int CW = $clog2(FLOW_ENTRIES + 1);

  fct_pkg::fct_state_t  state;
  fct_pkg::fct_state_t  state_next;
  fct_pkg::fct_job_t    job;
  fct_pkg::fct_status_t res_status;
  logic [IW-1:0]        res_idx;
  logic [CW-1:0]        used;
  logic [CW-1:0]        rd_ptr;
  logic                 cmp_vld;
  logic [IW-1:0]        cmp_idx;
  logic [fct_pkg::ENTRY_W-1:0] rd_data;
  logic                 issue;
  logic                 rd_en;
  logic                 hit;
  logic                 scan_end;
  logic                 full;
  logic                 wr_en;
  logic [IW+fct_pkg::FLOW_IDX_W-1:0] idx_wide;

  // Scan control: more entries to read, a match, or nothing left to compare.
  always_comb begin
    issue = rd_ptr < used;
    hit = cmp_vld && (rd_data == job.key);
    scan_end = !issue && !cmp_vld;
    full = (used == CW'(FLOW_ENTRIES));
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      fct_pkg::ENG_IDLE: begin
        if (start) begin
          state_next = job_in.lookup ? fct_pkg::ENG_SCAN : fct_pkg::ENG_DONE;
        end
      end
      fct_pkg::ENG_SCAN: begin
        if (hit || scan_end) begin
          state_next = fct_pkg::ENG_DONE;
        end
      end
      fct_pkg::ENG_DONE: begin
        if (out_free) begin
          state_next = fct_pkg::ENG_IDLE;
        end
      end
      default: state_next = fct_pkg::ENG_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    idle = (state == fct_pkg::ENG_IDLE);
    rd_en = (state == fct_pkg::ENG_SCAN) && issue;
    wr_en = (state == fct_pkg::ENG_DONE) && out_free &&
            ((res_status == fct_pkg::ST_TCP_NEW) || (res_status == fct_pkg::ST_UDP_NEW));
  end

  // Result fields; the index is masked to the result width.
  always_comb begin
    idx_wide = {{fct_pkg::FLOW_IDX_W{1'b0}}, res_idx};
    res.fire = (state == fct_pkg::ENG_DONE) && out_free;
    res.status = res_status;
    res.thl = job.thl;
    res.pay = job.pay;
    res.flow_index = idx_wide[fct_pkg::FLOW_IDX_W-1:0];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fct_pkg::ENG_IDLE;
      used <= '0;
      cmp_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        used <= used + CW'(1);
      end
      if (state == fct_pkg::ENG_IDLE) begin
        cmp_vld <= 1'b0;
      end else begin
        cmp_vld <= rd_en;
      end
    end
  end

  // Job and search registers.
  always_ff @(posedge clk) begin
    if (start && idle) begin
      job <= job_in;
      res_status <= job_in.status;
      res_idx <= '0;
      rd_ptr <= '0;
    end else if (state == fct_pkg::ENG_SCAN) begin
      if (rd_en) begin
        rd_ptr <= rd_ptr + CW'(1);
      end
      cmp_idx <= rd_ptr[IW-1:0];
      if (hit) begin
        res_status <= job.udp ? fct_pkg::ST_UDP_KNOWN : fct_pkg::ST_TCP_KNOWN;
        res_idx <= cmp_idx;
      end else if (scan_end) begin
        if (full) begin
          res_status <= job.udp ? fct_pkg::ST_UDP_FULL : fct_pkg::ST_TCP_FULL;
          res_idx <= '0;
        end else begin
          res_status <= job.udp ? fct_pkg::ST_UDP_NEW : fct_pkg::ST_TCP_NEW;
          res_idx <= used[IW-1:0];
        end
      end
    end
  end

  // Flow memory: new flows are appended at the fill count.
  fct_ram #(
    .WIDTH (fct_pkg::ENTRY_W),
    .DEPTH (FLOW_ENTRIES)
  ) u_flow_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (used[IW-1:0]),
    .wr_data (job.key),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr[IW-1:0]),
    .rd_data (rd_data)
  );

endmodule

@@ src/flow_tracking_packet_classifier_top.sv @@
// Top level of the flow-tracking packet classifier.
// Depends on fct_pkg, fct_if, fct_parse, fct_engine and fct_stats.
//
//   channel  dir  beat carries                      accepted when
//   in_ch    in   one packet's header fields        valid && ready
//   out_ch   out  status, lengths, index, counters  valid && ready
//   cfg_ch   in   port_filter write data            valid && ready
//
// A new packet is taken only while the engine is idle. A dropped packet goes
// from IDLE straight to DONE; a looked-up packet passes through SCAN, which
// ends at a hit or once every filled entry is compared: the flow memory has
// one read port and the scan compares one stored entry per cycle.
// Reset clears the counters, the fill count and the filter, not the flow memory.
// A waiting result does not block the next packet; cfg_ch is always ready.
module flow_tracking_packet_classifier_top #(
  parameter int FLOW_ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst,
  fct_in_if.sink       in_ch,
  fct_out_if.source    out_ch,
  fct_cfg_if.sink      cfg_ch
);

  fct_pkg::fct_in_t     pkt;
  fct_pkg::fct_job_t    job;
  fct_pkg::fct_result_t res;
  fct_pkg::fct_counts_t counts_next;
  logic [15:0]          port_filter;
  logic                 idle;
  logic                 start;
  logic                 out_free;
  logic                 out_valid;

  // Gather the packet beat.
  always_comb begin
    pkt.frame_type = in_ch.frame_type;
    pkt.ip_version = in_ch.ip_version;
    pkt.ip_header_words = in_ch.ip_header_words;
    pkt.next_protocol = in_ch.next_protocol;
    pkt.src_addr_hi = in_ch.src_addr_hi;
    pkt.src_addr_lo = in_ch.src_addr_lo;
    pkt.dst_addr_hi = in_ch.dst_addr_hi;
    pkt.dst_addr_lo = in_ch.dst_addr_lo;
    pkt.src_port = in_ch.src_port;
    pkt.dst_port = in_ch.dst_port;
    pkt.tcp_data_offset = in_ch.tcp_data_offset;
    pkt.captured_length = in_ch.captured_length;
  end

  // Handshakes.
  assign in_ch.ready = idle;
  assign start = in_ch.valid && idle;
  assign cfg_ch.ready = 1'b1;
  assign out_free = !out_valid || out_ch.ready;
  assign out_ch.valid = out_valid;

  // Filter register.
  always_ff @(posedge clk) begin
    if (rst) begin
      port_filter <= 16'd0;
    end else if (cfg_ch.valid) begin
      port_filter <= cfg_ch.port_filter;
    end
  end

  fct_parse u_parse (
    .pkt         (pkt),
    .port_filter (port_filter),
    .job         (job)
  );

  fct_engine #(
    .FLOW_ENTRIES (FLOW_ENTRIES)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .job_in   (job),
    .out_free (out_free),
    .idle     (idle),
    .res      (res)
  );

  fct_stats u_stats (
    .clk         (clk),
    .rst         (rst),
    .res         (res),
    .counts_next (counts_next)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (res.fire) begin
      out_ch.status <= res.status;
      out_ch.transport_header_len <= res.thl;
      out_ch.payload_len <= res.pay;
      out_ch.flow_index <= res.flow_index;
      out_ch.total_packets <= counts_next.total_packets;
      out_ch.tcp_packet_total <= counts_next.tcp_packet_total;
      out_ch.udp_packet_total <= counts_next.udp_packet_total;
      out_ch.tcp_byte_total <= counts_next.tcp_byte_total;
      out_ch.udp_byte_total <= counts_next.udp_byte_total;
      out_ch.tcp_flow_total <= counts_next.tcp_flow_total;
      out_ch.udp_flow_total <= counts_next.udp_flow_total;
    end
  end

endmodule

@@ src/fct_checker.sv @@
// Port-level checks of the classifier's result channel, bound to the top
// level. Depends on fct_pkg and flow_tracking_packet_classifier_top.
module fct_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  status,
  input logic [5:0]  thl,
  input logic [15:0] payload_len,
  input logic [5:0]  flow_index
);

  // A stalled result beat holds its status and index.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(flow_index))
    else $error("result changed while stalled");

  // Status stays within the defined codes.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= fct_pkg::ST_UDP_FULL)
    else $error("status out of range");

  // Dropped packets and a full table report index 0.
  a_no_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == fct_pkg::ST_NON_IP || status == fct_pkg::ST_NOT_L4 ||
                  status == fct_pkg::ST_FILTERED || status == fct_pkg::ST_TCP_FULL ||
                  status == fct_pkg::ST_UDP_FULL) |-> flow_index == 6'd0)
    else $error("flow index set without a flow");

  // Packets dropped before classification carry no lengths.
  a_drop_lengths: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == fct_pkg::ST_NON_IP || status == fct_pkg::ST_NOT_L4)
    |-> thl == 6'd0 && payload_len == 16'd0)
    else $error("lengths set on a dropped packet");

  // UDP results always report an 8-byte transport header.
  a_udp_thl: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == fct_pkg::ST_UDP_KNOWN || status == fct_pkg::ST_UDP_NEW ||
                  status == fct_pkg::ST_UDP_FULL) |-> thl == 6'd8)
    else $error("UDP header length wrong");

endmodule

bind flow_tracking_packet_classifier_top fct_checker u_fct_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .thl         (out_ch.transport_header_len),
  .payload_len (out_ch.payload_len),
  .flow_index  (out_ch.flow_index)
);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench of the flow-tracking packet classifier.
// Depends on fct_pkg, the fct_if channel interfaces and the classifier top level.
// A directed table and random traffic run against a flow table predictor kept here.
module tb_top;
  import fct_pkg::*;

  localparam int FLOW_ENTRIES = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TUPLE_POOL_MAX = 160;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_PACKETS = 200;
  localparam logic [63:0] HOST_A = 64'h0000_0000_0a00_0001;
  localparam logic [63:0] HOST_B = 64'h0000_0000_0a00_0002;
  localparam logic [63:0] ALL_ONES = '1;

  // Expected content of one result beat.
  typedef struct packed {
    fct_status_t status;
    logic [5:0]  thl;
    logic [15:0] pay;
    logic [5:0]  flow_index;
    fct_counts_t counts;
  } flow_verdict_t;

  // One line of the directed table: a filter write or a packet.
  typedef struct {
    bit          set_filter;
    logic [15:0] filter;
    fct_in_t     pkt;
    bit          typed;
    fct_status_t want_status;
    logic [5:0]  want_thl;
    logic [15:0] want_pay;
    logic [5:0]  want_idx;
  } plan_row_t;

  logic clk;
  logic rst;

  fct_in_if  in_ch ();
  fct_out_if out_ch ();
  fct_cfg_if cfg_ch ();

  flow_tracking_packet_classifier_top #(
    .FLOW_ENTRIES(FLOW_ENTRIES)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: flow keys, fill count, counters and the filter register.
  fct_entry_t    flow_keys [FLOW_ENTRIES];
  int            flows_filled = 0;
  fct_counts_t   tally = '0;
  logic [15:0]   active_filter = '0;

  flow_verdict_t awaited_results [$];
  fct_in_t       seen_tuples [$];
  plan_row_t     stimulus_plan [$];
  int            mismatches = 0;
  int            results_seen = 0;
  int            burst_left = 0;
  int            rx_holdoff = 0;
  int            cycle_count = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Works out the result of one accepted packet and advances the predictor state.
  function automatic flow_verdict_t classify_packet(input fct_in_t p);
    flow_verdict_t v;
    fct_entry_t    key;
    bit            is_udp;
    bit            is_v6;
    bit            hit;
    int            ip_bytes;
    int            hdr_bytes;
    int            i;
    v = '0;
    hit = 1'b0;
    tally.total_packets++;
    if (p.frame_type != ETH_IPV4 && p.frame_type != ETH_IPV6) begin
      v.status = ST_NON_IP;
    end else if ((p.ip_version != IP_VER4 && p.ip_version != IP_VER6) ||
                 (p.next_protocol != PROTO_TCP && p.next_protocol != PROTO_UDP)) begin
      v.status = ST_NOT_L4;
    end else begin
      is_udp = (p.next_protocol == PROTO_UDP);
      is_v6 = (p.ip_version == IP_VER6);
      v.thl = is_udp ? UDP_HDR_BYTES : {p.tcp_data_offset, 2'b00};
      if (active_filter != 16'd0 && p.src_port != active_filter) begin
        v.status = ST_FILTERED;
      end else begin
        // Lengths: the payload never goes below zero.
        ip_bytes = is_v6 ? int'(IPV6_HDR_BYTES) : 4 * int'(p.ip_header_words);
        hdr_bytes = int'(ETH_HDR_BYTES) + ip_bytes + int'(v.thl);
        if (int'(p.captured_length) > hdr_bytes) begin
          v.pay = 16'(int'(p.captured_length) - hdr_bytes);
        end
        // IPv4 keeps only the low 32 address bits in the key.
        key.src_hi = is_v6 ? p.src_addr_hi : 64'd0;
        key.src_lo = is_v6 ? p.src_addr_lo : {32'd0, p.src_addr_lo[31:0]};
        key.dst_hi = is_v6 ? p.dst_addr_hi : 64'd0;
        key.dst_lo = is_v6 ? p.dst_addr_lo : {32'd0, p.dst_addr_lo[31:0]};
        key.ports = {p.src_port, p.dst_port};
        key.tag = {is_v6, is_udp};
        if (is_udp) begin
          tally.udp_packet_total++;
          tally.udp_byte_total += 32'(v.pay);
        end else begin
          tally.tcp_packet_total++;
          tally.tcp_byte_total += 32'(v.pay);
        end
        // Lookup over the filled entries, then append or report a full table.
        for (i = 0; i < flows_filled; i++) begin
          if (!hit && flow_keys[i] == key) begin
            hit = 1'b1;
            v.flow_index = 6'(i);
          end
        end
        if (hit) begin
          if (is_udp) v.status = ST_UDP_KNOWN;
          else v.status = ST_TCP_KNOWN;
        end else if (flows_filled >= FLOW_ENTRIES) begin
          if (is_udp) v.status = ST_UDP_FULL;
          else v.status = ST_TCP_FULL;
        end else begin
          flow_keys[flows_filled] = key;
          v.flow_index = 6'(flows_filled);
          flows_filled++;
          if (is_udp) begin
            tally.udp_flow_total++;
            v.status = ST_UDP_NEW;
          end else begin
            tally.tcp_flow_total++;
            v.status = ST_TCP_NEW;
          end
        end
      end
    end
    v.counts = tally;
    return v;
  endfunction

  // Builds one packet's header fields for the directed table.
  function automatic fct_in_t headers(
    input logic [15:0] etype, input logic [3:0] ver, input logic [3:0] ihw,
    input logic [7:0] proto, input logic [63:0] sh, input logic [63:0] sl,
    input logic [63:0] dh, input logic [63:0] dl, input logic [15:0] sport,
    input logic [15:0] dport, input logic [3:0] doff, input logic [15:0] caplen
  );
    fct_in_t p;
    p.frame_type = etype;
    p.ip_version = ver;
    p.ip_header_words = ihw;
    p.next_protocol = proto;
    p.src_addr_hi = sh;
    p.src_addr_lo = sl;
    p.dst_addr_hi = dh;
    p.dst_addr_lo = dl;
    p.src_port = sport;
    p.dst_port = dport;
    p.tcp_data_offset = doff;
    p.captured_length = caplen;
    return p;
  endfunction

  // Appends a packet line; typed lines carry an expectation read off by hand.
  function automatic void add_row(input fct_in_t p, input bit typed = 1'b0,
                                  input fct_status_t st = ST_NON_IP, input int thl = 0,
                                  input int pay = 0, input int idx = 0);
    plan_row_t r;
    r.set_filter = 1'b0;
    r.filter = '0;
    r.pkt = p;
    r.typed = typed;
    r.want_status = st;
    r.want_thl = 6'(thl);
    r.want_pay = 16'(pay);
    r.want_idx = 6'(idx);
    stimulus_plan.push_back(r);
  endfunction

  function automatic void add_filter(input logic [15:0] value);
    plan_row_t r;
    r.set_filter = 1'b1;
    r.filter = value;
    r.pkt = '0;
    r.typed = 1'b0;
    r.want_status = ST_NON_IP;
    r.want_thl = '0;
    r.want_pay = '0;
    r.want_idx = '0;
    stimulus_plan.push_back(r);
  endfunction

  // Random traffic: mostly well-formed flows, often repeated, with some noise.
  function automatic fct_in_t random_packet();
    fct_in_t p;
    fct_in_t q;
    int      roll;
    roll = $urandom_range(0, 99);
    p.frame_type = 16'($urandom);
    p.ip_version = 4'($urandom);
    p.ip_header_words = 4'($urandom);
    p.next_protocol = 8'($urandom);
    p.src_addr_hi = {$urandom, $urandom};
    p.src_addr_lo = {$urandom, $urandom};
    p.dst_addr_hi = {$urandom, $urandom};
    p.dst_addr_lo = {$urandom, $urandom};
    p.src_port = 16'($urandom);
    p.dst_port = 16'($urandom);
    p.tcp_data_offset = 4'($urandom);
    p.captured_length = 16'($urandom);
    if (roll < 8) return p;
    p.frame_type = $urandom_range(0, 1) ? ETH_IPV6 : ETH_IPV4;
    // Broken headers: a bad version or a transport that is neither TCP nor UDP.
    if (roll < 14) begin
      if ($urandom_range(0, 1)) p.ip_version = $urandom_range(0, 1) ? IP_VER6 : IP_VER4;
      return p;
    end
    if (roll < 60 && seen_tuples.size() != 0) begin
      q = seen_tuples[$urandom_range(0, seen_tuples.size() - 1)];
      p.ip_version = q.ip_version;
      p.next_protocol = q.next_protocol;
      p.src_addr_hi = q.src_addr_hi;
      p.src_addr_lo = q.src_addr_lo;
      p.dst_addr_hi = q.dst_addr_hi;
      p.dst_addr_lo = q.dst_addr_lo;
      p.src_port = q.src_port;
      p.dst_port = q.dst_port;
      // An IPv4 flow must still match with junk in the unused address bits.
      if (p.ip_version != IP_VER6 && $urandom_range(0, 1)) begin
        p.src_addr_hi = {$urandom, $urandom};
        p.dst_addr_hi = {$urandom, $urandom};
        p.src_addr_lo[63:32] = $urandom;
        p.dst_addr_lo[63:32] = $urandom;
      end
    end else begin
      p.ip_version = $urandom_range(0, 1) ? IP_VER6 : IP_VER4;
      p.next_protocol = $urandom_range(0, 1) ? PROTO_UDP : PROTO_TCP;
      if (active_filter != 16'd0 && $urandom_range(0, 9) < 7) p.src_port = active_filter;
      if (seen_tuples.size() < TUPLE_POOL_MAX) seen_tuples.push_back(p);
    end
    if ($urandom_range(0, 9) != 0) begin
      p.frame_type = (p.ip_version == IP_VER6) ? ETH_IPV6 : ETH_IPV4;
    end
    if ($urandom_range(0, 3) != 0) begin
      p.ip_header_words = 4'd5;
      p.tcp_data_offset = 4'($urandom_range(5, 15));
    end
    case ($urandom_range(0, 3))
      0: p.captured_length = 16'($urandom_range(0, 120));
      1: p.captured_length = 16'($urandom_range(60, 1514));
      2: p.captured_length = 16'($urandom_range(65400, 65535));
      default: ;
    endcase
    return p;
  endfunction

  task automatic drive_fields(input fct_in_t p);
    in_ch.frame_type <= p.frame_type;
    in_ch.ip_version <= p.ip_version;
    in_ch.ip_header_words <= p.ip_header_words;
    in_ch.next_protocol <= p.next_protocol;
    in_ch.src_addr_hi <= p.src_addr_hi;
    in_ch.src_addr_lo <= p.src_addr_lo;
    in_ch.dst_addr_hi <= p.dst_addr_hi;
    in_ch.dst_addr_lo <= p.dst_addr_lo;
    in_ch.src_port <= p.src_port;
    in_ch.dst_port <= p.dst_port;
    in_ch.tcp_data_offset <= p.tcp_data_offset;
    in_ch.captured_length <= p.captured_length;
  endtask

  // Offers one packet beat and records its expectation once it is taken.
  task automatic send_packet(input plan_row_t r);
    flow_verdict_t v;
    drive_fields(r.pkt);
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    v = classify_packet(r.pkt);
    if (r.typed) begin
      v.status = r.want_status;
      v.thl = r.want_thl;
      v.pay = r.want_pay;
      v.flow_index = r.want_idx;
    end
    awaited_results.push_back(v);
  endtask

  // Sender bursts: after each burst a random gap, sometimes none at all.
  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // The filter is written only with no packet in flight.
  task automatic write_filter(input logic [15:0] value);
    in_ch.valid <= 1'b0;
    wait_drained();
    cfg_ch.port_filter <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    active_filter = value;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("result %0d: %s got 0x%0h, expected 0x%0h", results_seen, what, got, want);
    end
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Compares one result beat with the oldest expectation.
  task automatic check_result();
    flow_verdict_t w;
    results_seen++;
    if (awaited_results.size() == 0) begin
      report_mismatch("unexpected result beat, status", 64'(out_ch.status), 'x);
    end else begin
      w = awaited_results.pop_front();
      check_field("status", 64'(out_ch.status), 64'(w.status));
      check_field("transport_header_len", 64'(out_ch.transport_header_len), 64'(w.thl));
      check_field("payload_len", 64'(out_ch.payload_len), 64'(w.pay));
      check_field("flow_index", 64'(out_ch.flow_index), 64'(w.flow_index));
      check_field("total_packets", 64'(out_ch.total_packets),
                  64'(w.counts.total_packets));
      check_field("tcp_packet_total", 64'(out_ch.tcp_packet_total),
                  64'(w.counts.tcp_packet_total));
      check_field("udp_packet_total", 64'(out_ch.udp_packet_total),
                  64'(w.counts.udp_packet_total));
      check_field("tcp_byte_total", 64'(out_ch.tcp_byte_total),
                  64'(w.counts.tcp_byte_total));
      check_field("udp_byte_total", 64'(out_ch.udp_byte_total),
                  64'(w.counts.udp_byte_total));
      check_field("tcp_flow_total", 64'(out_ch.tcp_flow_total),
                  64'(w.counts.tcp_flow_total));
      check_field("udp_flow_total", 64'(out_ch.udp_flow_total),
                  64'(w.counts.udp_flow_total));
    end
  endtask

  // Result side: checks each beat and stalls on its own changing pattern.
  initial begin
    int rx_mode;
    int rx_left;
    int rx_phase;
    rx_mode = 0;
    rx_left = 0;
    rx_phase = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) check_result();
      if (rx_holdoff > 0) begin
        rx_holdoff--;
        out_ch.ready <= 1'b0;
      end else begin
        if (rx_left <= 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(16, 128);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= (rx_phase % 3 == 0);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Run limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** flow_tracking_packet_classifier_top: FAILED **");
    $finish;
  end

  // Packet side: reset, the directed table, then random phases.
  initial begin
    plan_row_t   row;
    logic [15:0] filt;
    int          ph;
    int          n;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    drive_fields('0);
    cfg_ch.valid <= 1'b0;
    cfg_ch.port_filter <= '0;

    // Header extremes, both drop reasons, new, known and masked flows, filtering.
    add_row(headers(16'h0000, 4'd0, 4'd0, 8'd0, 64'd0, 64'd0, 64'd0, 64'd0,
                    16'd0, 16'd0, 4'd0, 16'd0), 1, ST_NON_IP);
    add_row(headers(16'hFFFF, 4'hF, 4'hF, 8'hFF, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                    16'hFFFF, 16'hFFFF, 4'hF, 16'hFFFF), 1, ST_NON_IP);
    add_row(headers(ETH_IPV4, 4'd5, 4'd5, PROTO_TCP, 64'd0, HOST_A, 64'd0, HOST_B,
                    16'd1000, 16'd80, 4'd5, 16'd100), 1, ST_NOT_L4);
    add_row(headers(ETH_IPV4, IP_VER4, 4'd5, 8'd0, 64'd0, HOST_A, 64'd0, HOST_B,
                    16'd1000, 16'd80, 4'd5, 16'd100), 1, ST_NOT_L4);
    add_row(headers(ETH_IPV6, IP_VER6, 4'd0, 8'hFF, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                    16'd1, 16'd2, 4'd5, 16'd100), 1, ST_NOT_L4);
    add_row(headers(ETH_IPV4, IP_VER4, 4'd5, PROTO_TCP, 64'd0, HOST_A, 64'd0, HOST_B,
                    16'd1000, 16'd80, 4'd5, 16'd64), 1, ST_TCP_NEW, 20, 10, 0);
    add_row(headers(ETH_IPV4, IP_VER4, 4'd5, PROTO_TCP, 64'd0, HOST_A, 64'd0, HOST_B,
                    16'd1000, 16'd80, 4'd5, 16'd1514), 1, ST_TCP_KNOWN, 20, 1460, 0);
    add_row(headers(ETH_IPV4, IP_VER4, 4'd5, PROTO_UDP, 64'd0, HOST_A, 64'd0, HOST_B,
                    16'd53, 16'd53, 4'd0, 16'd42), 1, ST_UDP_NEW, 8, 0, 1);
    add_row(headers(ETH_IPV6, IP_VER6, 4'd0, PROTO_TCP, ALL_ONES, ALL_ONES, ALL_ONES,
                    ALL_ONES, 16'hFFFF, 16'hFFFF, 4'hF, 16'hFFFF),
            1, ST_TCP_NEW, 60, 65421, 2);
    add_row(headers(ETH_IPV6, IP_VER6, 4'd0, PROTO_UDP, ALL_ONES, ALL_ONES, ALL_ONES,
                    ALL_ONES, 16'd0, 16'd0, 4'd0, 16'd0), 1, ST_UDP_NEW, 8, 0, 3);
    add_row(headers(ETH_IPV4, IP_VER4, 4'd5, PROTO_TCP, ALL_ONES, 64'hFFFF_FFFF_0a00_0001,
                    ALL_ONES, 64'hA5A5_A5A5_0a00_0002, 16'd1000, 16'd80, 4'd5, 16'd54),
            1, ST_TCP_KNOWN, 20, 0, 0);
    add_row(headers(ETH_IPV4, IP_VER4, 4'd0, PROTO_TCP, 64'd0, 64'd0, 64'd0, 64'd0,
                    16'd0, 16'd0, 4'd0, 16'd13), 1, ST_TCP_NEW, 0, 0, 4);
    add_row(headers(ETH_IPV4, IP_VER4, 4'hF, PROTO_TCP, 64'd0, HOST_A, 64'd0, HOST_B,
                    16'd1, 16'd2, 4'hF, 16'd200), 1, ST_TCP_NEW, 60, 66, 5);
    // Ether type and version disagree: the version decides the key and lengths.
    add_row(headers(ETH_IPV6, IP_VER4, 4'd5, PROTO_TCP, 64'd0, HOST_A, 64'd0, HOST_B,
                    16'd1000, 16'd80, 4'd5, 16'd64));
    add_row(headers(ETH_IPV4, IP_VER6, 4'd0, PROTO_UDP, ALL_ONES, ALL_ONES, ALL_ONES,
                    ALL_ONES, 16'd0, 16'd0, 4'd0, 16'd100));
    // Same addresses and ports under another version or protocol are new flows.
    add_row(headers(ETH_IPV6, IP_VER6, 4'd0, PROTO_UDP, 64'd0, HOST_A, 64'd0, HOST_B,
                    16'd53, 16'd53, 4'd0, 16'd100));
    add_row(headers(ETH_IPV4, IP_VER4, 4'd5, PROTO_UDP, 64'd0, HOST_A, 64'd0, HOST_B,
                    16'd1000, 16'd80, 4'd5, 16'd300));
    add_filter(16'hFFFF);
    add_row(headers(ETH_IPV4, IP_VER4, 4'd5, PROTO_TCP, 64'd0, HOST_A, 64'd0, HOST_B,
                    16'd1234, 16'd80, 4'd5, 16'd500), 1, ST_FILTERED, 20, 0, 0);
    add_row(headers(ETH_IPV4, IP_VER4, 4'd5, PROTO_UDP, 64'd0, HOST_A, 64'd0, HOST_B,
                    16'd0, 16'd80, 4'd5, 16'd500), 1, ST_FILTERED, 8, 0, 0);
    add_row(headers(ETH_IPV4, IP_VER4, 4'd5, PROTO_TCP, 64'd0, HOST_A, 64'd0, HOST_B,
                    16'hFFFF, 16'd7, 4'd8, 16'd80), 1, ST_TCP_NEW, 32, 14, 8);
    add_row(headers(ETH_IPV6, IP_VER6, 4'd0, PROTO_TCP, ALL_ONES, ALL_ONES, ALL_ONES,
                    ALL_ONES, 16'hFFFF, 16'hFFFF, 4'hF, 16'd1000));
    add_filter(16'h0000);
    add_row(headers(ETH_IPV6, 4'd0, 4'd5, PROTO_TCP, 64'd0, HOST_A, 64'd0, HOST_B,
                    16'd1, 16'd2, 4'd5, 16'd100), 1, ST_NOT_L4);
    add_row(headers(16'h0801, IP_VER4, 4'd5, PROTO_UDP, 64'd0, HOST_A, 64'd0, HOST_B,
                    16'd1, 16'd2, 4'd5, 16'd100), 1, ST_NON_IP);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    foreach (stimulus_plan[i]) begin
      if (stimulus_plan[i].set_filter) begin
        write_filter(stimulus_plan[i].filter);
      end else begin
        send_packet(stimulus_plan[i]);
        pace();
      end
    end

    // Random phases, each under its own filter setting.
    row.set_filter = 1'b0;
    row.filter = '0;
    row.typed = 1'b0;
    row.want_status = ST_NON_IP;
    row.want_thl = '0;
    row.want_pay = '0;
    row.want_idx = '0;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        1: filt = 16'hFFFF;
        2: filt = (seen_tuples.size() != 0) ?
                  seen_tuples[$urandom_range(0, seen_tuples.size() - 1)].src_port : 16'h8000;
        3: filt = 16'h0001;
        5: filt = 16'($urandom_range(1, 65535));
        default: filt = 16'h0000;
      endcase
      write_filter(filt);
      // A long result stall while packets keep coming backs the block up.
      if (ph == 1) rx_holdoff = 400;
      for (n = 0; n < PHASE_PACKETS; n++) begin
        row.pkt = random_packet();
        send_packet(row);
        pace();
      end
    end

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (FLOW_ENTRIES + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("** flow_tracking_packet_classifier_top: PASSED **");
    end else begin
      $display("** flow_tracking_packet_classifier_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/fct_pkg.sv
src/fct_if.sv
src/fct_ram.sv
src/fct_parse.sv
src/fct_stats.sv
src/fct_engine.sv
src/flow_tracking_packet_classifier_top.sv
src/fct_checker.sv
tb/sv/tb_top.sv
